// ===== sv/tsd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the degree-input Taylor sine pipeline.
// Holds fixed-point widths, the radian scale constant and the lane types.
// No dependencies.
package tsd_pkg;

  localparam int unsigned ANG_W      = 16;
  localparam int unsigned AMAG_W     = 15;
  localparam int unsigned ANG_LIMIT  = 23040;
  localparam int unsigned RAD_W      = 37;
  localparam logic [RAD_W-1:0] RAD_PER_DEG =
    RAD_W'(((64'd3141592 << 42) + 64'd90000000) / 64'd180000000);

  localparam int unsigned FRAC_W     = 48;
  localparam int unsigned X_W        = 51;
  localparam int unsigned X2_W       = 54;
  localparam int unsigned T_W        = 55;
  localparam int unsigned N_W        = 61;
  localparam int unsigned RECIP_W    = 64;
  localparam int unsigned SUM_W      = 58;

  localparam int unsigned SINE_W     = 32;
  localparam int unsigned OUT_SHIFT  = 18;
  localparam int unsigned MAG_W      = SUM_W - OUT_SHIFT;

  typedef struct packed {
    logic                    sgn;
    logic [X2_W-1:0]         x2;
    logic signed [SUM_W-1:0] sum;
  } tsd_side_t;

  typedef struct packed {
    tsd_side_t       side;
    logic [T_W-1:0]  t;
  } tsd_lane_t;

endpackage

// ===== sv/tsd_mul.sv =====
`timescale 1ns / 1ps
// Two-stage unsigned multiplier built from four 32-bit partial products.
// Stand-alone; used by tsd_front and tsd_term.
module tsd_mul #(
  parameter int unsigned AW = 40,
  parameter int unsigned BW = 40
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic [AW+BW-1:0]   p_o
);

  localparam int unsigned LW  = 32;
  localparam int unsigned AHW = AW - LW;
  localparam int unsigned BHW = BW - LW;
  localparam int unsigned PW  = AW + BW;

  logic [2*LW-1:0]    ll_d, ll_q;
  logic [LW+BHW-1:0]  lh_d, lh_q;
  logic [AHW+LW-1:0]  hl_d, hl_q;
  logic [AHW+BHW-1:0] hh_d, hh_q;
  logic [PW-1:0]      p_d, p_q;

  always_comb begin
    ll_d = (2*LW)'(a_i[LW-1:0]) * (2*LW)'(b_i[LW-1:0]);
    lh_d = (LW+BHW)'(a_i[LW-1:0]) * (LW+BHW)'(b_i[BW-1:LW]);
    hl_d = (AHW+LW)'(a_i[AW-1:LW]) * (AHW+LW)'(b_i[LW-1:0]);
    hh_d = (AHW+BHW)'(a_i[AW-1:LW]) * (AHW+BHW)'(b_i[BW-1:LW]);
    p_d  = PW'(ll_q) + (PW'(lh_q) << LW) + (PW'(hl_q) << LW) + (PW'(hh_q) << (2*LW));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/tsd_front.sv =====
`timescale 1ns / 1ps
// Front end: clamp the angle, scale to Q48 radians, square with rounding.
// Depends on tsd_pkg and tsd_mul.
module tsd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic signed [tsd_pkg::ANG_W-1:0] angle_i,
  output logic                       vld_o,
  output tsd_pkg::tsd_lane_t         lane_o
);

  localparam int unsigned AW  = tsd_pkg::ANG_W;
  localparam int unsigned XPW = tsd_pkg::AMAG_W + tsd_pkg::RAD_W;
  localparam int unsigned SPW = 2 * tsd_pkg::X_W;

  logic [4:0]                     vld_q;
  logic                           sgn1_q, sgn2_q, sgn3_q, sgn4_q;
  logic [tsd_pkg::AMAG_W-1:0]     amag_d, amag_q;
  logic [tsd_pkg::X_W-1:0]        xmag_d, xmag2_q, xmag3_q, xmag4_q;
  logic signed [AW-1:0]           ang_c;
  logic [AW-1:0]                  ang_abs;
  logic [XPW-1:0]                 xprod;
  logic [SPW-1:0]                 sq, sq_rnd;
  tsd_pkg::tsd_lane_t             lane_d, lane_q;

  always_comb begin
    ang_c = angle_i;
    if (angle_i > $signed(AW'(tsd_pkg::ANG_LIMIT))) begin
      ang_c = $signed(AW'(tsd_pkg::ANG_LIMIT));
    end else if (angle_i < -$signed(AW'(tsd_pkg::ANG_LIMIT))) begin
      ang_c = -$signed(AW'(tsd_pkg::ANG_LIMIT));
    end
    ang_abs = ang_c[AW-1] ? AW'(-ang_c) : AW'(ang_c);
    amag_d  = ang_abs[tsd_pkg::AMAG_W-1:0];
    xprod   = XPW'(amag_q) * XPW'(tsd_pkg::RAD_PER_DEG);
    xmag_d  = xprod[tsd_pkg::X_W-1:0];
    sq_rnd  = sq + (SPW'(1) << (tsd_pkg::FRAC_W - 1));
    lane_d.side.sgn = sgn4_q;
    lane_d.side.x2  = sq_rnd[tsd_pkg::FRAC_W +: tsd_pkg::X2_W];
    lane_d.side.sum = sgn4_q ? -$signed(tsd_pkg::SUM_W'(xmag4_q))
                             :  $signed(tsd_pkg::SUM_W'(xmag4_q));
    lane_d.t        = tsd_pkg::T_W'(xmag4_q);
  end

  tsd_mul #(.AW(tsd_pkg::X_W), .BW(tsd_pkg::X_W)) u_sq (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (xmag2_q),
    .b_i   (xmag2_q),
    .p_o   (sq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn1_q  <= ang_c[AW-1];
      amag_q  <= amag_d;
      sgn2_q  <= sgn1_q;
      xmag2_q <= xmag_d;
      sgn3_q  <= sgn2_q;
      xmag3_q <= xmag2_q;
      sgn4_q  <= sgn3_q;
      xmag4_q <= xmag3_q;
      lane_q  <= lane_d;
    end
  end

  assign vld_o  = vld_q[4];
  assign lane_o = lane_q;

endmodule

// ===== sv/tsd_term.sv =====
`timescale 1ns / 1ps
// One series term: multiply by x^2, round, divide by (n-1)*n, accumulate.
// Depends on tsd_pkg and tsd_mul.
module tsd_term #(
  parameter int unsigned K = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  tsd_pkg::tsd_lane_t lane_i,
  output logic               vld_o,
  output tsd_pkg::tsd_lane_t lane_o
);

  localparam int unsigned DIV      = (2 * K - 2) * (2 * K - 1);
  localparam int unsigned DIV_HALF = DIV / 2;
  localparam int unsigned SHIFT    = tsd_pkg::N_W + $clog2(DIV);
  localparam logic [tsd_pkg::RECIP_W-1:0] RECIP = tsd_pkg::RECIP_W'(
    ((128'd1 << SHIFT) + 128'(DIV) - 128'd1) / 128'(DIV));
  localparam int unsigned P1W = tsd_pkg::T_W + tsd_pkg::X2_W;
  localparam int unsigned P2W = tsd_pkg::N_W + tsd_pkg::RECIP_W;
  localparam int unsigned PADW = tsd_pkg::SUM_W - tsd_pkg::T_W;

  logic [5:0]                 vld_q;
  tsd_pkg::tsd_side_t         sd1_q, sd2_q, sd3_q, sd4_q, sd5_q;
  logic [P1W-1:0]             p1, p1_rnd;
  logic [P2W-1:0]             p2;
  logic [tsd_pkg::N_W-1:0]    n_d, n_q;
  logic [tsd_pkg::T_W-1:0]    q;
  logic signed [tsd_pkg::SUM_W-1:0] qs;
  tsd_pkg::tsd_lane_t         lane_d, lane_q;

  tsd_mul #(.AW(tsd_pkg::T_W), .BW(tsd_pkg::X2_W)) u_mul_x2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (lane_i.t),
    .b_i   (lane_i.side.x2),
    .p_o   (p1)
  );

  tsd_mul #(.AW(tsd_pkg::N_W), .BW(tsd_pkg::RECIP_W)) u_mul_recip (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (n_q),
    .b_i   (RECIP),
    .p_o   (p2)
  );

  always_comb begin
    p1_rnd = p1 + (P1W'(1) << (tsd_pkg::FRAC_W - 1));
    n_d    = p1_rnd[tsd_pkg::FRAC_W +: tsd_pkg::N_W] + tsd_pkg::N_W'(DIV_HALF);
    q      = tsd_pkg::T_W'(p2 >> SHIFT);
    qs     = $signed({{PADW{1'b0}}, q});
    lane_d.side.sgn = ~sd5_q.sgn;
    lane_d.side.x2  = sd5_q.x2;
    lane_d.side.sum = sd5_q.sgn ? sd5_q.sum + qs : sd5_q.sum - qs;
    lane_d.t        = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd1_q  <= lane_i.side;
      sd2_q  <= sd1_q;
      sd3_q  <= sd2_q;
      n_q    <= n_d;
      sd4_q  <= sd3_q;
      sd5_q  <= sd4_q;
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q[5];
  assign lane_o = lane_q;

endmodule

// ===== sv/tsd_back.sv =====
`timescale 1ns / 1ps
// Back end: round the Q48 sum to Q1.30 and saturate to plus or minus one.
// Depends on tsd_pkg.
module tsd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic signed [tsd_pkg::SUM_W-1:0]   sum_i,
  output logic                               vld_o,
  output logic signed [tsd_pkg::SINE_W-1:0]  sine_o
);

  localparam int unsigned SW = tsd_pkg::SUM_W;
  localparam int unsigned OW = tsd_pkg::SINE_W;
  localparam int unsigned MW = tsd_pkg::MAG_W;

  logic                 vld_q;
  logic [SW-1:0]        abs_v, rnd_v;
  logic [MW-1:0]        mag, one_v;
  logic [OW-1:0]        mag_s;
  logic signed [OW-1:0] sine_d, sine_q;

  always_comb begin
    abs_v  = sum_i[SW-1] ? SW'(-sum_i) : SW'(sum_i);
    rnd_v  = abs_v + (SW'(1) << (tsd_pkg::OUT_SHIFT - 1));
    mag    = rnd_v[SW-1:tsd_pkg::OUT_SHIFT];
    one_v  = MW'(1) << (OW - 2);
    mag_s  = (mag > one_v) ? OW'(one_v) : OW'(mag);
    sine_d = sum_i[SW-1] ? -$signed(mag_s) : $signed(mag_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= sine_d;
    end
  end

  assign vld_o  = vld_q;
  assign sine_o = sine_q;

endmodule

// ===== sv/taylor_sine_degrees.sv =====
`timescale 1ns / 1ps
// Taylor-series sine of an angle in degrees, fully pipelined.
// Depends on tsd_pkg, tsd_front, tsd_term, tsd_back and tsd_mul.
//
// Input channel: angle_deg_i (signed Q9.6 degrees) with in_valid_i and in_ready_o.
// Angles beyond plus or minus 360 degrees are clamped. Output channel: sine_o
// (signed Q1.30, saturated to plus or minus one) with out_valid_o and out_ready_i.
// A word is moved when valid and ready are both high at a rising edge.
//
// Throughput: one word per cycle while in_ready_o is high. From the accepting edge
// to out_valid_o a word passes the front end (5 stages), six stages per series
// term (two 2-stage multipliers, a rounding stage and an accumulate stage), one
// rounding stage and the output register.
//
// When the receiver stalls, the pipeline still advances into a one-word skid
// register; only once that is full does the whole pipeline hold and in_ready_o
// drop. Nothing is lost or repeated. Reset clears every valid bit, those of the
// output and skid registers included; data registers are not reset.
module taylor_sine_degrees #(
  parameter int unsigned TERMS = 17
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [tsd_pkg::ANG_W-1:0]   angle_deg_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tsd_pkg::SINE_W-1:0]  sine_o
);

  logic                               en;
  logic [TERMS-1:0]                   vld;
  tsd_pkg::tsd_lane_t                 lane [TERMS];
  logic                               back_vld;
  logic signed [tsd_pkg::SINE_W-1:0]  back_sine;
  logic                               out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic signed [tsd_pkg::SINE_W-1:0]  out_d, out_q, skid_d, skid_q;
  logic                               take;

  assign en = ~skid_vld_q;

  tsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .angle_i (angle_deg_i),
    .vld_o   (vld[0]),
    .lane_o  (lane[0])
  );

  for (genvar k = 2; k <= TERMS; k++) begin : g_term
    tsd_term #(.K(k)) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k-2]),
      .lane_i (lane[k-2]),
      .vld_o  (vld[k-1]),
      .lane_o (lane[k-1])
    );
  end

  tsd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld[TERMS-1]),
    .sum_i  (lane[TERMS-1].side.sum),
    .vld_o  (back_vld),
    .sine_o (back_sine)
  );

  always_comb begin
    take       = out_vld_q & out_ready_i;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (back_vld) begin
      if (!out_vld_q || take) begin
        out_d     = back_sine;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = back_sine;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;
  assign sine_o      = out_q;

endmodule
